FILE: src/p1su_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p1su_pkg
// Shared types and constants of the 1-bit scanline unfilter.
// ----------------------------------------------------------------------------
package p1su_pkg;

  localparam int DEF_MAX_WIDTH = 4096;
  localparam int CFG_W         = 13;
  localparam logic [CFG_W-1:0] WIDTH_RESET = 13'd8;

  typedef logic [2:0] filt_t;

  localparam filt_t FILT_NONE  = 3'd0;
  localparam filt_t FILT_SUB   = 3'd1;
  localparam filt_t FILT_UP    = 3'd2;
  localparam filt_t FILT_AVG   = 3'd3;
  localparam filt_t FILT_PAETH = 3'd4;

  typedef struct packed {
    filt_t      kind;
    logic [7:0] x;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
  } pred_in_t;

endpackage

FILE: src/p1su_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p1su_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module p1su_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/p1su_predict.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p1su_predict
// Filter predictor and byte reconstruction for one data byte.
// ----------------------------------------------------------------------------
module p1su_predict
  import p1su_pkg::*;
(
  input  pred_in_t   pin,
  output logic [7:0] r
);

  logic [8:0] sum_ab;
  logic [9:0] pa;
  logic [9:0] pb;
  logic [9:0] pc;
  logic [9:0] ab_w;
  logic [9:0] c2_w;
  logic [7:0] paeth;
  logic [7:0] pred;

  always_comb begin
    sum_ab = {1'b0, pin.a} + {1'b0, pin.b};
    ab_w   = {1'b0, sum_ab};
    c2_w   = {1'b0, pin.c, 1'b0};
    pa = (pin.b > pin.c) ? 10'(pin.b - pin.c) : 10'(pin.c - pin.b);
    pb = (pin.a > pin.c) ? 10'(pin.a - pin.c) : 10'(pin.c - pin.a);
    pc = (ab_w > c2_w) ? (ab_w - c2_w) : (c2_w - ab_w);
    if (pa <= pb && pa <= pc) begin
      paeth = pin.a;
    end else if (pb <= pc) begin
      paeth = pin.b;
    end else begin
      paeth = pin.c;
    end
    case (pin.kind)
      FILT_SUB:   pred = pin.a;
      FILT_UP:    pred = pin.b;
      FILT_AVG:   pred = sum_ab[8:1];
      FILT_PAETH: pred = paeth;
      default:    pred = 8'd0;
    endcase
    r = pin.x + pred;
  end

endmodule

FILE: src/png_1bit_scanline_unfilter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_1bit_scanline_unfilter
// Undoes PNG scanline filters on a 1-bit image byte stream.
//
// Input channel: in_byte and part_start under in_valid / in_stall. Each line
// is a filter byte followed by ceil(width/8) data bytes; part_start on a byte
// restarts the image and takes that byte as a filter byte.
// Output channel: one result per request, out_byte / line_end / bad_filter
// under out_valid / out_stall. The filter position yields 0, data bytes the
// reconstructed value with padding bits past the width cleared.
// Config: cfg_wr_en / cfg_wr_data set the width in pixels; write while idle.
// At accept the line store read is issued and the byte enters the stage
// register, where it is rebuilt; the result is then registered at the
// output with out_valid. Throughput is one byte per cycle while out_stall is low.
// A stalled result holds in the output register while one more request may
// enter the stage register; in_stall rises only when both are full.
// Reset clears control state and sets the width to 8; the line store is not
// cleared and the first line after a part start reads zeros above.
// ----------------------------------------------------------------------------
module png_1bit_scanline_unfilter
  import p1su_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int DEPTH = (MAX_WIDTH + 7) / 8,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int COL_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_byte,
  input  logic             part_start,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             line_end,
  output logic             bad_filter
);

  logic [CFG_W-1:0] line_width;
  logic [CFG_W-1:0] eff_w;
  logic [CFG_W:0]   nbytes_sum;
  logic [CFG_W-3:0] nbytes;
  logic [7:0]       tail_mask;

  logic [COL_W-1:0] col_track;
  logic [COL_W-1:0] col_track_next;
  logic             first_track;
  logic             first_track_next;
  logic [COL_W-1:0] in_col;
  logic [COL_W-1:0] in_col_m1;
  logic             in_last;
  logic             in_first;
  logic             in_accept;

  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic             s1_filter;
  logic             s1_last;
  logic             s1_first;
  logic [AW-1:0]    s1_addr;
  logic             s1_adv;

  filt_t            filter_kind;
  logic [7:0]       left_byte;
  logic [7:0]       upleft_byte;
  logic [7:0]       above_rd;
  logic [7:0]       above_b;
  logic [7:0]       recon;
  logic             s1_bad;
  pred_in_t         pin;

  // width clamp, bytes per line and padding mask
  always_comb begin
    if (line_width == '0) begin
      eff_w = CFG_W'(1);
    end else if (32'(line_width) > MAX_WIDTH) begin
      eff_w = CFG_W'(MAX_WIDTH);
    end else begin
      eff_w = line_width;
    end
    nbytes_sum = {1'b0, eff_w} + (CFG_W+1)'(7);
    nbytes     = nbytes_sum[CFG_W:3];
    if (eff_w[2:0] == 3'd0) begin
      tail_mask = 8'hFF;
    end else begin
      tail_mask = 8'(8'hFF << (4'd8 - {1'b0, eff_w[2:0]}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= WIDTH_RESET;
    end else if (cfg_wr_en) begin
      line_width <= cfg_wr_data;
    end
  end

  // handshake
  assign s1_adv    = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  // column tracking at the input side
  always_comb begin
    in_col    = part_start ? '0 : col_track;
    in_first  = part_start ? 1'b1 : first_track;
    in_col_m1 = in_col - COL_W'(1);
    in_last   = 32'(in_col) >= 32'(nbytes);
    col_track_next   = col_track;
    first_track_next = first_track;
    if (in_accept) begin
      first_track_next = in_first;
      if (in_col == '0) begin
        col_track_next = COL_W'(1);
      end else if (in_last) begin
        col_track_next   = '0;
        first_track_next = 1'b0;
      end else begin
        col_track_next = in_col + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_track   <= '0;
      first_track <= 1'b1;
      s1_valid    <= 1'b0;
    end else begin
      col_track   <= col_track_next;
      first_track <= first_track_next;
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte   <= in_byte;
      s1_filter <= (in_col == '0);
      s1_last   <= in_last;
      s1_first  <= in_first;
      s1_addr   <= in_col_m1[AW-1:0];
    end
  end

  p1su_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_above (
    .clk     (clk),
    .wr_en   (s1_adv && !s1_filter),
    .wr_addr (s1_addr),
    .wr_data (recon),
    .rd_en   (in_accept),
    .rd_addr (in_col_m1[AW-1:0]),
    .rd_data (above_rd)
  );

  // reconstruction
  always_comb begin
    above_b  = s1_first ? 8'd0 : above_rd;
    pin.kind = filter_kind;
    pin.x    = s1_byte;
    pin.a    = left_byte;
    pin.b    = above_b;
    pin.c    = upleft_byte;
    s1_bad   = s1_byte > 8'(FILT_PAETH);
  end

  p1su_predict u_predict (
    .pin (pin),
    .r   (recon)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_kind <= FILT_NONE;
      left_byte   <= 8'd0;
      upleft_byte <= 8'd0;
    end else if (s1_adv) begin
      if (s1_filter) begin
        filter_kind <= s1_bad ? FILT_NONE : s1_byte[2:0];
        left_byte   <= 8'd0;
        upleft_byte <= 8'd0;
      end else begin
        left_byte   <= recon;
        upleft_byte <= above_b;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      if (s1_filter) begin
        out_byte   <= 8'd0;
        line_end   <= 1'b0;
        bad_filter <= s1_bad;
      end else begin
        out_byte   <= recon & (s1_last ? tail_mask : 8'hFF);
        line_end   <= s1_last;
        bad_filter <= 1'b0;
      end
    end
  end

  a_bad_is_filter_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_filter |-> out_byte == 8'd0 && !line_end)
    else $error("bad_filter on a data byte result");

  a_stall_needs_stage: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled with free pipeline space");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    32'(col_track) <= DEPTH)
    else $error("column counter past line store depth");

  a_last_wraps: assert property (@(posedge clk) disable iff (rst)
    in_accept && in_col != '0 && in_last |=> col_track == '0 && !first_track)
    else $error("line end did not restart column");

endmodule

FILE: sim/tb_png_1bit_scanline_unfilter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_png_1bit_scanline_unfilter
// Self-checking bench for the 1-bit scanline unfilter. A scoreboard class
// rebuilds every byte of the stream from its own copy of the line store and
// filter state and checks each result in order. The stimulus has a directed
// part for every filter, the padding masks, bad filter types, part starts and
// width changes. A random part follows with mostly well-formed lines, some
// broken lines, random idle gaps on the input and random output stalls.
// ----------------------------------------------------------------------------
module tb_png_1bit_scanline_unfilter;
  import p1su_pkg::*;

  typedef struct {
    logic [7:0] pix;
    logic       last;
    logic       bad;
  } rebuilt_t;

  class unfilter_checker;
    logic [CFG_W-1:0] width;
    logic [7:0]       above [DEF_MAX_WIDTH/8];
    int unsigned      column;
    filt_t            kind;
    logic [7:0]       left_px;
    logic [7:0]       upleft_px;
    bit               first_line;
    rebuilt_t         expected_q [$];
    int               errors;

    function new();
      width      = WIDTH_RESET;
      column     = 0;
      kind       = FILT_NONE;
      left_px    = 8'd0;
      upleft_px  = 8'd0;
      first_line = 1'b1;
      errors     = 0;
    endfunction

    function int unsigned clamp_width(logic [CFG_W-1:0] w);
      if (w == 0) return 1;
      if (w > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
      return 32'(w);
    endfunction

    function int unsigned bytes_per_line(logic [CFG_W-1:0] w);
      return (clamp_width(w) + 7) >> 3;
    endfunction

    function logic [7:0] paeth_pick(logic [7:0] a, logic [7:0] b, logic [7:0] c);
      int pa, pb, pc;
      pa = int'(b) - int'(c);
      pb = int'(a) - int'(c);
      pc = int'(a) + int'(b) - 2 * int'(c);
      if (pa < 0) pa = -pa;
      if (pb < 0) pb = -pb;
      if (pc < 0) pc = -pc;
      if (pa <= pb && pa <= pc) return a;
      if (pb <= pc) return b;
      return c;
    endfunction

    function void note_request(logic [7:0] x, logic ps);
      rebuilt_t    r;
      int unsigned w, n, idx;
      logic [7:0]  b, pred, val, mask;
      logic [8:0]  sum;
      w = clamp_width(width);
      n = (w + 7) >> 3;
      if (ps) begin
        first_line = 1'b1;
        column = 0;
      end
      if (column == 0) begin
        r.pix     = 8'd0;
        r.last    = 1'b0;
        r.bad     = (x > 8'(FILT_PAETH));
        kind      = r.bad ? FILT_NONE : filt_t'(x[2:0]);
        left_px   = 8'd0;
        upleft_px = 8'd0;
        column    = 1;
      end else begin
        idx = (column - 1) % (DEF_MAX_WIDTH / 8);
        b = first_line ? 8'd0 : above[idx];
        sum = {1'b0, left_px} + {1'b0, b};
        case (kind)
          FILT_SUB:   pred = left_px;
          FILT_UP:    pred = b;
          FILT_AVG:   pred = sum[8:1];
          FILT_PAETH: pred = paeth_pick(left_px, b, upleft_px);
          default:    pred = 8'd0;
        endcase
        val = x + pred;
        above[idx] = val;
        left_px    = val;
        upleft_px  = b;
        r.last = (column >= n);
        mask = 8'hFF;
        if (r.last) begin
          if (w % 8 != 0) mask = 8'hFF << (8 - w % 8);
          column = 0;
          first_line = 1'b0;
        end else begin
          column++;
        end
        r.pix = val & mask;
        r.bad = 1'b0;
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [7:0] pix, logic last, logic bad);
      rebuilt_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors < 50)
          $display("%0t unexpected result: out_byte %h line_end %b bad_filter %b",
                   $time, pix, last, bad);
        return;
      end
      e = expected_q.pop_front();
      if (pix !== e.pix) begin
        errors++;
        if (errors < 50)
          $display("%0t out_byte mismatch: expected %h, got %h", $time, e.pix, pix);
      end
      if (last !== e.last) begin
        errors++;
        if (errors < 50)
          $display("%0t line_end mismatch: expected %b, got %b", $time, e.last, last);
      end
      if (bad !== e.bad) begin
        errors++;
        if (errors < 50)
          $display("%0t bad_filter mismatch: expected %b, got %b", $time, e.bad, bad);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       in_byte = 8'd0;
  logic             part_start = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [7:0]       out_byte;
  logic             line_end;
  logic             bad_filter;

  unfilter_checker sb = new();
  bit tx_quiet;
  bit rx_quiet;
  bit need_ps;
  int stall_run;
  bit stall_now;
  int n_sent;

  png_1bit_scanline_unfilter dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .part_start  (part_start),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .line_end    (line_end),
    .bad_filter  (bad_filter)
  );

  always #6 clk = ~clk;

  // result side: check and random stall runs
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(out_byte, line_end, bad_filter);
    if (stall_run > 0) begin
      stall_run--;
    end else if (rx_quiet) begin
      stall_now = 1'b0;
      stall_run = $urandom_range(1, 20);
    end else begin
      stall_now = ($urandom_range(0, 2) == 0);
      if (!stall_now) stall_run = $urandom_range(1, 8);
      else if ($urandom_range(0, 9) == 0) stall_run = $urandom_range(10, 40);
      else stall_run = $urandom_range(1, 3);
    end
    out_stall <= stall_now;
  end

  function automatic int tx_gap();
    int r;
    if (tx_quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] rand_data();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_req(input logic [7:0] b, input logic ps);
    int   gap;
    logic ps_eff;
    ps_eff = ps | need_ps;
    need_ps = 1'b0;
    in_valid   <= 1'b1;
    in_byte    <= b;
    part_start <= ps_eff;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(b, ps_eff);
    n_sent++;
    gap = tx_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_line(input logic [7:0] kind, input logic ps, input int ndata);
    send_req(kind, ps);
    for (int i = 0; i < ndata; i++) send_req(rand_data(), 1'b0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // a wider line would read store entries never written, so restart the part
  task automatic write_width(input logic [CFG_W-1:0] w);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (sb.bytes_per_line(w) > sb.bytes_per_line(sb.width)) need_ps = 1'b1;
    sb.width = w;
  endtask

  initial begin
    int               nlines, n;
    logic [7:0]       kind;
    logic             ps;
    logic [CFG_W-1:0] w;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset width of 8
    send_req(8'(FILT_NONE), 1'b1);
    send_req(8'hA5, 1'b0);
    // 20 pixels: three bytes, last one keeps four bits
    write_width(13'd20);
    send_req(8'(FILT_SUB), 1'b1);
    send_req(8'hFF, 1'b0); send_req(8'h01, 1'b0); send_req(8'h80, 1'b0);
    send_req(8'(FILT_UP), 1'b0);
    send_req(8'h00, 1'b0); send_req(8'hFF, 1'b0); send_req(8'h7F, 1'b0);
    send_req(8'(FILT_AVG), 1'b0);
    send_req(8'hFF, 1'b0); send_req(8'hFF, 1'b0); send_req(8'h01, 1'b0);
    send_req(8'(FILT_PAETH), 1'b0);
    send_req(8'h80, 1'b0); send_req(8'h00, 1'b0); send_req(8'hFF, 1'b0);
    send_req(8'd5, 1'b0);
    send_req(8'h12, 1'b0); send_req(8'h34, 1'b0); send_req(8'hF0, 1'b0);
    // part start in mid-line, then narrowing in mid-line ends the line
    send_req(8'(FILT_UP), 1'b0);
    send_req(8'h3C, 1'b0);
    send_req(8'(FILT_AVG), 1'b1);
    send_req(8'hC3, 1'b0);
    write_width(13'd8);
    send_req(8'h5A, 1'b0);

    // width extremes
    write_width(13'd0);
    send_line(8'(FILT_SUB), 1'b0, 1);
    send_line(8'(FILT_PAETH), 1'b0, 1);
    write_width(13'h1FFF);
    send_line(8'(FILT_PAETH), 1'b1, sb.bytes_per_line(sb.width));
    write_width(13'd4096);
    send_line(8'(FILT_UP), 1'b0, sb.bytes_per_line(sb.width));

    while (n_sent < 1150) begin
      case ($urandom_range(0, 19))
        0:       w = 13'd1;
        1:       w = 13'd0;
        2:       w = 13'($urandom_range(65, 300));
        default: w = 13'($urandom_range(1, 64));
      endcase
      write_width(w);
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      nlines = $urandom_range(2, 10);
      for (int l = 0; l < nlines && n_sent < 1150; l++) begin
        if ($urandom_range(0, 9) == 0) kind = 8'($urandom_range(5, 255));
        else kind = 8'($urandom_range(0, 4));
        ps = ($urandom_range(0, 7) == 0);
        n = sb.bytes_per_line(sb.width);
        // broken line: stop early, usually restarting the part after it
        if ($urandom_range(0, 11) == 0) begin
          send_line(kind, ps, $urandom_range(0, n - 1));
          need_ps = ($urandom_range(0, 3) != 0);
        end else begin
          send_line(kind, ps, n);
        end
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: sim.f
src/p1su_pkg.sv
src/p1su_ram.sv
src/p1su_predict.sv
src/png_1bit_scanline_unfilter.sv
sim/tb_png_1bit_scanline_unfilter.sv
